### hdl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// Shared constants and types of the bitmap text run rasterizer.
// ----------------------------------------------------------------------------
package btr_pkg;

  localparam int GLYPH_SIZE  = 8;
  localparam int ROW_IDX_W   = 3;
  localparam int RUN_LEN_W   = 4;
  localparam int SCALE_W     = 5;
  localparam int OFFS_W      = 8;

  localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;

  localparam logic [SCALE_W-1:0] SCALE_MIN = 5'd1;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 5'd16;

  // One horizontal run found in a glyph row, plus the row with it removed.
  typedef struct packed {
    logic                  found;
    logic [ROW_IDX_W-1:0]  start;
    logic [RUN_LEN_W-1:0]  len;
    logic [GLYPH_SIZE-1:0] rest;
  } run_t;

endpackage

### hdl/bitmap_text_run_rasterizer.sv
// ----------------------------------------------------------------------------
// bitmap_text_run_rasterizer
// Turns a stream of characters with 8x8 glyph bitmaps into run rectangles.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_axis carries one character, its glyph bitmap
// and, with tuser high, the pixel origin of a new string. The block keeps a
// text cursor and the x of the line origin. A newline returns the cursor to
// the line origin and moves it down by eight scaled pixels; other codes
// outside the printable range only move the cursor right. For a printable
// character every horizontal run of set bits becomes one rectangle beat on
// m_axis, row 0 first and low bit first in a row, with tlast on the final
// rectangle of the character. Blank glyphs give no beats.
// Sequencing: a character is taken while idle, then a small sequencer walks
// the glyph with one shared saturating adder: a dispatch step, a row step
// for each glyph row up to the last non-empty row (just one for a blank
// glyph), a run step for each rectangle and an advance step for the cursor.
// A newline or control code ends after the dispatch step; a character gives
// at most 32 rectangles. s_axis_tready is high only between characters. A
// stalled receiver holds the rectangle in the output register and the
// sequencer waits. Reset clears the cursor and line origin to zero and the
// scale register to 1. The scale register may be written while no character
// is in flight; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module bitmap_text_run_rasterizer import btr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Scale register write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [4:0]    cfg_data_i,     // pixel_scale
  // Character input.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // start_x[15:0], start_y[31:16], char_code[39:32], glyph_bits[103:40]
  input  logic [103:0]  s_axis_tdata,
  input  logic          s_axis_tuser,   // first_of_string
  // Rectangle output.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // rect_x[15:0], rect_y[31:16], rect_width[39:32], rect_height[44:40], zeros
  output logic [47:0]   m_axis_tdata,
  output logic          m_axis_tlast    // last_rect
);

  localparam int WIDE = (COORD_BITS > 16) ? COORD_BITS : 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROW,
    ST_RUN,
    ST_ADVANCE
  } state_e;

  state_e state_q;

  logic [SCALE_W-1:0]           scale_q;
  logic [SCALE_W-1:0]           eff_scale;
  logic signed [COORD_BITS-1:0] cur_x_q;
  logic signed [COORD_BITS-1:0] cur_y_q;
  logic signed [COORD_BITS-1:0] line_x_q;
  logic signed [COORD_BITS-1:0] row_y_q;
  logic [7:0]                   code_q;
  logic [63:0]                  glyph_q;
  logic [GLYPH_SIZE-1:0]        row_bits_q;
  logic [ROW_IDX_W-1:0]         row_idx_q;

  logic                         out_valid_q;
  logic [15:0]                  rect_x_q;
  logic [15:0]                  rect_y_q;
  logic [7:0]                   rect_w_q;
  logic [SCALE_W-1:0]           rect_h_q;
  logic                         last_q;

  logic signed [COORD_BITS-1:0] add_base;
  logic [RUN_LEN_W-1:0]         mul_a;
  logic [OFFS_W-1:0]            mul_prod;
  logic [OFFS_W-1:0]            width_prod;
  logic signed [COORD_BITS-1:0] add_sum;
  run_t                         run;
  logic                         s_fire;
  logic                         out_free;
  logic                         is_print;

  // Origins arrive as 16-bit values; fit them into the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_origin(input logic [15:0] v);
    logic signed [WIDE-1:0] ext;
    logic signed [WIDE-1:0] hi;
    logic signed [WIDE-1:0] lo;
    ext = WIDE'(signed'(v));
    hi  = WIDE'(signed'({1'b0, {(COORD_BITS-1){1'b1}}}));
    lo  = -hi - WIDE'(signed'(2'sb01));
    if (ext > hi) begin
      ext = hi;
    end else if (ext < lo) begin
      ext = lo;
    end
    return COORD_BITS'(ext);
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign is_print      = (code_q >= FIRST_PRINTABLE) && (code_q <= LAST_PRINTABLE);

  // A scale of zero behaves as one, and anything above sixteen as sixteen.
  always_comb begin
    if (scale_q == '0) begin
      eff_scale = SCALE_MIN;
    end else if (scale_q > SCALE_MAX) begin
      eff_scale = SCALE_MAX;
    end else begin
      eff_scale = scale_q;
    end
  end

  // Operand selection for the shared adder: the cursor advance, the row
  // offset or the run start offset, each a small multiple of the scale.
  always_comb begin
    case (state_q)
      ST_DISPATCH: begin
        add_base = (code_q == NEWLINE_CODE) ? cur_y_q : cur_x_q;
        mul_a    = RUN_LEN_W'(GLYPH_SIZE);
      end
      ST_ROW: begin
        add_base = cur_y_q;
        mul_a    = RUN_LEN_W'(row_idx_q);
      end
      ST_RUN: begin
        add_base = cur_x_q;
        mul_a    = RUN_LEN_W'(run.start);
      end
      default: begin
        add_base = cur_x_q;
        mul_a    = RUN_LEN_W'(GLYPH_SIZE);
      end
    endcase
  end

  // Both products stay at or below 8 times 16, so eight bits hold them.
  assign mul_prod   = OFFS_W'(mul_a) * OFFS_W'(eff_scale);
  assign width_prod = OFFS_W'(run.len) * OFFS_W'(eff_scale);

  btr_sat_add #(
    .COORD_BITS (COORD_BITS)
  ) u_add (
    .base_i (add_base),
    .offs_i (mul_prod),
    .sum_o  (add_sum)
  );

  btr_run_find u_find (
    .row_i (row_bits_q),
    .run_o (run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= SCALE_MIN;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      line_x_q    <= '0;
      out_valid_q <= 1'b0;
      row_idx_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end

      // In the run state the output register is reloaded instead.
      if (out_valid_q && m_axis_tready && (state_q != ST_RUN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            code_q    <= s_axis_tdata[39:32];
            glyph_q   <= s_axis_tdata[103:40];
            row_idx_q <= '0;
            if (s_axis_tuser) begin
              cur_x_q  <= sat_origin(s_axis_tdata[15:0]);
              cur_y_q  <= sat_origin(s_axis_tdata[31:16]);
              line_x_q <= sat_origin(s_axis_tdata[15:0]);
            end
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (code_q == NEWLINE_CODE) begin
            cur_x_q <= line_x_q;
            cur_y_q <= add_sum;
            state_q <= ST_IDLE;
          end else if (!is_print) begin
            cur_x_q <= add_sum;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_ROW;
          end
        end
        ST_ROW: begin
          // Empty rows are skipped; once nothing is left the cursor moves on.
          if (glyph_q == '0) begin
            state_q <= ST_ADVANCE;
          end else begin
            row_bits_q <= glyph_q[GLYPH_SIZE-1:0];
            glyph_q    <= glyph_q >> GLYPH_SIZE;
            row_y_q    <= add_sum;
            row_idx_q  <= row_idx_q + ROW_IDX_W'(1);
            if (glyph_q[GLYPH_SIZE-1:0] != '0) begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            rect_x_q    <= 16'(add_sum);
            rect_y_q    <= 16'(row_y_q);
            rect_w_q    <= width_prod;
            rect_h_q    <= eff_scale;
            last_q      <= (run.rest == '0) && (glyph_q == '0);
            row_bits_q  <= run.rest;
            if (run.rest != '0) begin
              state_q <= ST_RUN;
            end else if (glyph_q != '0) begin
              state_q <= ST_ROW;
            end else begin
              state_q <= ST_ADVANCE;
            end
          end
        end
        ST_ADVANCE: begin
          cur_x_q <= add_sum;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, rect_h_q, rect_w_q, rect_y_q, rect_x_q};
  assign m_axis_tlast  = last_q;

endmodule

### hdl/btr_sat_add.sv
// ----------------------------------------------------------------------------
// btr_sat_add
// Shared coordinate adder: signed coordinate plus unsigned pixel offset,
// saturated to the signed coordinate range.
// ----------------------------------------------------------------------------
module btr_sat_add import btr_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0] base_i,
  input  logic        [OFFS_W-1:0]     offs_i,
  output logic signed [COORD_BITS-1:0] sum_o
);

  logic [COORD_BITS:0] sum_wide;

  assign sum_wide = {base_i[COORD_BITS-1], base_i} + (COORD_BITS+1)'(offs_i);

  // The offset is never negative, so only the positive limit can be crossed.
  always_comb begin
    if (!sum_wide[COORD_BITS] && sum_wide[COORD_BITS-1]) begin
      sum_o = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      sum_o = sum_wide[COORD_BITS-1:0];
    end
  end

endmodule

### hdl/btr_run_find.sv
// ----------------------------------------------------------------------------
// btr_run_find
// Finds the lowest run of set bits in one glyph row and clears it.
// ----------------------------------------------------------------------------
module btr_run_find import btr_pkg::*; (
  input  logic [GLYPH_SIZE-1:0] row_i,
  output run_t                  run_o
);

  logic [GLYPH_SIZE-1:0] shifted;
  logic [GLYPH_SIZE:0]   mask;
  logic                  seen;
  logic                  stop;

  always_comb begin
    run_o.found = |row_i;
    run_o.start = '0;
    seen        = 1'b0;
    for (int i = 0; i < GLYPH_SIZE; i++) begin
      if (row_i[i] && !seen) begin
        run_o.start = ROW_IDX_W'(i);
        seen        = 1'b1;
      end
    end

    // Count the ones that follow the start bit without a gap.
    shifted   = row_i >> run_o.start;
    run_o.len = '0;
    stop      = 1'b0;
    for (int i = 0; i < GLYPH_SIZE; i++) begin
      if (shifted[i] && !stop) begin
        run_o.len = run_o.len + RUN_LEN_W'(1);
      end else begin
        stop = 1'b1;
      end
    end

    mask       = ((GLYPH_SIZE+1)'(1) << run_o.len) - (GLYPH_SIZE+1)'(1);
    run_o.rest = row_i & ~(mask[GLYPH_SIZE-1:0] << run_o.start);
  end

endmodule

### bench/bitmap_text_run_checker.sv
// ----------------------------------------------------------------------------
// bitmap_text_run_checker
// Predicts and checks the rectangle beats of the text run rasterizer.
// ----------------------------------------------------------------------------
// Watches the scale write channel and the character stream. It keeps its own
// pen position, line margin and scale, and queues the rectangles that every
// accepted character must produce. Each rectangle beat on the output is
// compared field by field with the oldest queued rectangle.
// ----------------------------------------------------------------------------
module bitmap_text_run_checker import btr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [4:0]   cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // start_x[15:0], start_y[31:16], char_code[39:32], glyph_bits[103:40]
  input  logic [103:0] s_tdata_i,
  input  logic         s_tuser_i,     // first_of_string
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // rect_x[15:0], rect_y[31:16], rect_width[39:32], rect_height[44:40], zeros
  input  logic [47:0]  m_tdata_i,
  input  logic         m_tlast_i,     // last_rect
  output int           errors_o,
  output int           rects_due_o
);

  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic [7:0]         width;
    logic [SCALE_W-1:0] height;
    logic               last;
  } rect_t;

  rect_t              awaited_rects[$];
  logic [SCALE_W-1:0] scale_reg  = SCALE_MIN;
  logic signed [15:0] pen_x      = '0;
  logic signed [15:0] pen_y      = '0;
  logic signed [15:0] margin_x   = '0;
  int                 mismatches = 0;

  function automatic logic [15:0] clamp_coord(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // Out-of-range register values are pinned to the nearest legal scale.
  function automatic int scale_in_use(logic [SCALE_W-1:0] r);
    if (r < SCALE_MIN) return int'(SCALE_MIN);
    if (r > SCALE_MAX) return int'(SCALE_MAX);
    return int'(r);
  endfunction

  // Updates the pen for one character and queues its run rectangles.
  task automatic draw_char(input logic first, input logic [103:0] beat);
    logic [7:0]  code;
    logic [63:0] glyph;
    logic [7:0]  row_bits;
    int          s;
    int          row;
    int          col;
    int          start;
    rect_t       held;
    logic        have_held;
    code      = beat[39:32];
    glyph     = beat[103:40];
    s         = scale_in_use(scale_reg);
    held      = '0;
    have_held = 1'b0;
    if (first) begin
      pen_x    = beat[15:0];
      pen_y    = beat[31:16];
      margin_x = beat[15:0];
    end
    if (code == NEWLINE_CODE) begin
      pen_x = margin_x;
      pen_y = clamp_coord(int'(pen_y) + GLYPH_SIZE * s);
    end else if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) begin
      pen_x = clamp_coord(int'(pen_x) + GLYPH_SIZE * s);
    end else begin
      for (row = 0; row < GLYPH_SIZE; row++) begin
        row_bits = glyph[8*row +: 8];
        col = 0;
        while (col < GLYPH_SIZE) begin
          if (!row_bits[col]) begin
            col++;
          end else begin
            start = col;
            while (col < GLYPH_SIZE && row_bits[col]) col++;
            // The previous run is now known not to be the last one.
            if (have_held) awaited_rects.push_back(held);
            held.x     = clamp_coord(int'(pen_x) + start * s);
            held.y     = clamp_coord(int'(pen_y) + row * s);
            held.width = 8'((col - start) * s);
            held.height = SCALE_W'(s);
            held.last  = 1'b0;
            have_held  = 1'b1;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        awaited_rects.push_back(held);
      end
      pen_x = clamp_coord(int'(pen_x) + GLYPH_SIZE * s);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    rect_t got;
    rect_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[15:0], m_tdata_i[31:16], m_tdata_i[39:32], m_tdata_i[44:40],
               m_tlast_i};
        if (awaited_rects.size() == 0) begin
          $error("unexpected rectangle beat: x=%0d y=%0d width=%0d height=%0d last=%0d",
                 $signed(got.x), $signed(got.y), got.width, got.height, got.last);
          mismatches++;
        end else begin
          want = awaited_rects.pop_front();
          if (got.x !== want.x) begin
            $error("rect_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
            mismatches++;
          end
          if (got.y !== want.y) begin
            $error("rect_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
            mismatches++;
          end
          if (got.width !== want.width) begin
            $error("rect_width: expected %0d, got %0d", want.width, got.width);
            mismatches++;
          end
          if (got.height !== want.height) begin
            $error("rect_height: expected %0d, got %0d", want.height, got.height);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_rect: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) scale_reg = cfg_data_i;
      if (s_tvalid_i && s_tready_i) draw_char(s_tuser_i, s_tdata_i);
    end
    errors_o    <= mismatches;
    rects_due_o <= awaited_rects.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bitmap text run rasterizer.
// ----------------------------------------------------------------------------
// A short directed sequence covers the glyph extremes, the code classes and
// coordinate saturation. Then the run steps through a list of scale settings;
// in each one it sends random strings of characters with random glyphs and
// origins. The sender works in bursts, the receiver stalls on patterns of its
// own, and once the receiver holds off long enough to back the block up. The
// checker module predicts every rectangle and counts mismatches.
// ----------------------------------------------------------------------------
module testbench import btr_pkg::*; ();

  localparam int RESET_CYCLES    = 11;
  // Wait after the last rectangle, with margin for a character with 32 runs.
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int PHASES          = 10;
  localparam int FIXED_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int SQUEEZE_PHASE   = 3;
  localparam int STEADY_PHASE    = 6;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  // Scale settings per phase: extremes, out-of-range values and a few in
  // between. The phases after these draw a random register value.
  localparam logic [SCALE_W-1:0] SCALE_PLAN [FIXED_PHASES] =
    '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd5, 5'd8};

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [4:0]   cfg_data_i    = SCALE_MIN;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // start_x[15:0], start_y[31:16], char_code[39:32], glyph_bits[103:40]
  logic [103:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;  // first_of_string
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // rect_x[15:0], rect_y[31:16], rect_width[39:32], rect_height[44:40], zeros
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tlast;          // last_rect

  int   errors;
  int   rects_due;

  // Phase controls. The receiver reads these, so they change by nonblocking
  // assignment at a clock edge. tx_steady is only read by the sender itself.
  int   phase_id   = 0;
  logic squeeze    = 1'b0;
  logic rx_steady  = 1'b0;
  logic tx_steady  = 1'b0;
  int   burst_left = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  bitmap_text_run_rasterizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bitmap_text_run_checker rect_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .errors_o    (errors),
    .rects_due_o (rects_due)
  );

  // Glyphs: blank, solid, the two checkerboards that give the most runs per
  // character, fully random bits, and sparse font-like rows.
  function automatic logic [63:0] rand_glyph();
    logic [63:0] g;
    int          r;
    g = '0;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = '1;
      2: g = {8{8'h55}};
      3: g = {8{8'hAA}};
      4, 5: g = {$urandom, $urandom};
      default: begin
        for (r = 0; r < GLYPH_SIZE; r++)
          if ($urandom_range(0, 3) != 0) g[8*r +: 8] = 8'($urandom) & 8'($urandom);
      end
    endcase
    return g;
  endfunction

  // Origins near zero, near either end of the coordinate range, or anywhere.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 600)) - 16'd300;
      1: return 16'h7FFF - 16'($urandom_range(0, 200));
      2: return 16'h8000 + 16'($urandom_range(0, 200));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one character beat and returns once it is accepted. Outside the
  // steady phases, between bursts of random length the sender drops tvalid
  // for a random gap, occasionally a long one.
  task automatic send_char(input logic first, input logic [15:0] org_x,
                           input logic [15:0] org_y, input logic [7:0] code,
                           input logic [63:0] glyph);
    if (!tx_steady && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 25 : 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= first;
    s_axis_tdata  <= {glyph, code, org_y, org_x};
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  // Stops offering characters, waits until every predicted rectangle has
  // arrived, then lets the block finish any character that produces no
  // beats. rects_due is registered in the checker, hence the first edge.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (rects_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: switches between stall patterns of random length. In the
  // squeeze phase it holds tready low for a long count of cycles while the
  // sender keeps offering, so the output register fills and the block stops
  // taking characters.
  initial begin : receiver
    rx_mode_e mode;
    int       mode_left;
    int       period;
    int       held_phase;
    mode       = RX_OPEN;
    mode_left  = 0;
    period     = 2;
    held_phase = -1;
    forever begin
      @(posedge clk_i);
      if (squeeze && phase_id != held_phase) begin
        held_phase = phase_id;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
          period    = $urandom_range(2, 5);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= (mode_left % period == 0);
        endcase
      end
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          placed;
    int          len;
    int          i;
    logic        carry;
    logic        first;
    logic [7:0]  code;
    logic [4:0]  scale;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the scale the block resets to. A solid glyph gives
    // one full-width run per row; the checkerboards give the maximum of four
    // runs per row.
    send_char(1'b1, 16'h0000, 16'h0000, 8'h41, '1);
    send_char(1'b0, 16'h0000, 16'h0000, FIRST_PRINTABLE, {8{8'h55}});
    send_char(1'b0, 16'h0000, 16'h0000, LAST_PRINTABLE, {8{8'hAA}});
    // Codes just outside the printable range, the two byte extremes and a
    // tab only advance the pen, whatever the glyph holds.
    send_char(1'b0, 16'h0000, 16'h0000, FIRST_PRINTABLE - 8'd1, rand_glyph());
    send_char(1'b0, 16'h0000, 16'h0000, LAST_PRINTABLE + 8'd1, '1);
    send_char(1'b0, 16'h0000, 16'h0000, 8'h00, '1);
    send_char(1'b0, 16'h0000, 16'h0000, 8'hFF, '1);
    send_char(1'b0, 16'h0000, 16'h0000, 8'h09, '1);
    // Newline with a non-blank glyph, then a printable but blank character.
    send_char(1'b0, 16'h0000, 16'h0000, NEWLINE_CODE, '1);
    send_char(1'b0, 16'h0000, 16'h0000, 8'h42, '0);
    // Near the top of the coordinate range the rectangles and the pen clamp.
    send_char(1'b1, 16'h7FF8, 16'h7FFC, 8'h58, '1);
    send_char(1'b0, 16'h0000, 16'h0000, 8'h59, 64'h8100_0000_0000_0081);
    send_char(1'b0, 16'h0000, 16'h0000, NEWLINE_CODE, '0);
    send_char(1'b0, 16'h0000, 16'h0000, 8'h5A, '1);
    // Most negative origin, one pixel in the last column of each row.
    send_char(1'b1, 16'h8000, 16'h8000, 8'h5A, {8{8'h80}});
    send_char(1'b0, 16'h0000, 16'h0000, NEWLINE_CODE, '1);
    // Small negative origin; later origin fields are ignored without tuser.
    send_char(1'b1, 16'hFFFB, 16'hFFFD, 8'h61, 64'h8100_0000_0000_0081);
    send_char(1'b0, 16'hFFFF, 16'hFFFF, 8'h62, 64'h00FF_00FF_00FF_00FF);
    send_char(1'b0, 16'h1234, 16'h5678, 8'h63, rand_glyph());

    // Random part: one scale setting per phase, written while idle.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      scale = (phase < FIXED_PHASES) ? SCALE_PLAN[phase] : 5'($urandom_range(0, 31));
      write_scale(scale);
      phase_id  <= phase;
      squeeze   <= (phase == SQUEEZE_PHASE);
      rx_steady <= (phase == STEADY_PHASE);
      tx_steady  = (phase == SQUEEZE_PHASE || phase == STEADY_PHASE);
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        len = $urandom_range(1, 12);
        // Sometimes the first string of a phase continues the previous one,
        // so the new scale applies in the middle of a line.
        carry = (placed == 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
          // A rare restart in the middle of a string acts as noise.
          first = (i == 0 && !carry) || ($urandom_range(0, 19) == 0);
          case ($urandom_range(0, 9))
            0: code = NEWLINE_CODE;
            1: code = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 31))
                                                  : 8'($urandom_range(127, 255));
            default: code = 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
          endcase
          send_char(first, rand_coord(), rand_coord(), code, rand_glyph());
        end
        placed += len;
      end
    end

    settle();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### bitmap_text_run_rasterizer.f
hdl/btr_pkg.sv
hdl/btr_sat_add.sv
hdl/btr_run_find.sv
hdl/bitmap_text_run_rasterizer.sv
bench/bitmap_text_run_checker.sv
bench/testbench.sv
